// File: rtl/core/fpsl_pkg.sv
// Shared constants for the motor-fader PID drive with settle release.
// Field widths, register map codes and fixed limits; no dependencies.

package fpsl_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register map, word index = paddr[4:2]
    localparam logic [2:0] REG_KP_GAIN        = 3'd0;
    localparam logic [2:0] REG_KI_GAIN        = 3'd1;
    localparam logic [2:0] REG_KD_GAIN        = 3'd2;
    localparam logic [2:0] REG_LOCK_WINDOW    = 3'd3;
    localparam logic [2:0] REG_LOCK_COUNT     = 3'd4;
    localparam logic [2:0] REG_COUNT_HEADROOM = 3'd5;
    localparam logic [2:0] REG_LOCK_DELAY_MS  = 3'd6;
    localparam logic [2:0] REG_HOLD_MODE      = 3'd7;

    localparam logic CMD_SET_TARGET = 1'b0;
    localparam logic CMD_STEP       = 1'b1;

    localparam logic [9:0] TGT_MIN   = 10'd2;
    localparam logic [9:0] TGT_MAX   = 10'd1021;
    localparam logic [9:0] TGT_RESET = 10'd512;

    localparam logic signed [11:0] INTEG_LIMIT     = 12'sd300;
    localparam logic signed [8:0]  DRIVE_LIMIT     = 9'sd240;
    localparam logic signed [8:0]  HOLD_DRIVE_LIMIT = 9'sd100;

    // Reset values of the configuration registers
    localparam logic [15:0] KP_RESET        = 16'd256;
    localparam logic [15:0] KI_RESET        = 16'd0;
    localparam logic [15:0] KD_RESET        = 16'd0;
    localparam logic [9:0]  WINDOW_RESET    = 10'd4;
    localparam logic [15:0] LOCK_CNT_RESET  = 16'd50;
    localparam logic [15:0] HEADROOM_RESET  = 16'd50;
    localparam logic [15:0] DELAY_RESET     = 16'd300;

    // Products and their sum fit comfortably in 30 signed bits
    localparam int SUM_W = 30;
    localparam int DRV_W = SUM_W - 8;

endpackage

// File: rtl/core/fader_pid_with_settle_lock_top.sv
// Motor-fader PID drive with settle counter, touch-release hold and integral clamp.
// Depends on fpsl_pkg for register codes, limits and widths.
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid/in_stall  | command, new_target, position, touched, now_ms
//   out     | from block| out_valid/out_stall| drive, released, current_target
//   cfg     | to block  | APB psel/penable   | 8 registers at 4*i, 32-bit data
//
// One transaction per cycle sustained while out does not stall. A control step passes
// from the input register, which feeds the state update, to the operand register, which
// feeds the three gain multiplies, sum and clamp, and then to the output register.
// A set-target transaction only updates state and produces no result.
// Reset clears state and configuration at once; no clearing pass.
// A stall on out backs up through the operand and input registers to in_stall.

module fader_pid_with_settle_lock_top
    import fpsl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [9:0]               new_target,
    input  logic [9:0]               position,
    input  logic                     touched,
    input  logic [31:0]              now_ms,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [8:0]        drive,
    output logic                     released,
    output logic [9:0]               current_target,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    // ---------------------------------------------------------------- config
    logic [15:0] kp_reg, ki_reg, kd_reg;
    logic [9:0]  window_reg;
    logic [15:0] lock_cnt_reg, headroom_reg, delay_reg;
    logic        hold_mode_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= KP_RESET;
            ki_reg        <= KI_RESET;
            kd_reg        <= KD_RESET;
            window_reg    <= WINDOW_RESET;
            lock_cnt_reg  <= LOCK_CNT_RESET;
            headroom_reg  <= HEADROOM_RESET;
            delay_reg     <= DELAY_RESET;
            hold_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_KP_GAIN:        kp_reg        <= pwdata[15:0];
                REG_KI_GAIN:        ki_reg        <= pwdata[15:0];
                REG_KD_GAIN:        kd_reg        <= pwdata[15:0];
                REG_LOCK_WINDOW:    window_reg    <= pwdata[9:0];
                REG_LOCK_COUNT:     lock_cnt_reg  <= pwdata[15:0];
                REG_COUNT_HEADROOM: headroom_reg  <= pwdata[15:0];
                REG_LOCK_DELAY_MS:  delay_reg     <= pwdata[15:0];
                REG_HOLD_MODE:      hold_mode_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_KP_GAIN:        prdata = {16'd0, kp_reg};
            REG_KI_GAIN:        prdata = {16'd0, ki_reg};
            REG_KD_GAIN:        prdata = {16'd0, kd_reg};
            REG_LOCK_WINDOW:    prdata = {22'd0, window_reg};
            REG_LOCK_COUNT:     prdata = {16'd0, lock_cnt_reg};
            REG_COUNT_HEADROOM: prdata = {16'd0, headroom_reg};
            REG_LOCK_DELAY_MS:  prdata = {16'd0, delay_reg};
            REG_HOLD_MODE:      prdata = {31'd0, hold_mode_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------- pipeline control
    logic a_valid_reg, b_valid_reg, out_valid_reg;
    logic a_move, b_move, b_free, c_free, a_step_move, in_accept;

    logic        a_cmd_reg;
    logic [9:0]  a_tgt_reg, a_pos_reg;
    logic        a_touch_reg;
    logic [31:0] a_now_reg;

    assign c_free      = !out_valid_reg || !out_stall;
    assign b_move      = b_valid_reg && c_free;
    assign b_free      = !b_valid_reg || b_move;
    assign a_move      = a_valid_reg && ((a_cmd_reg == CMD_SET_TARGET) || b_free);
    assign a_step_move = a_move && (a_cmd_reg == CMD_STEP);
    assign in_stall    = a_valid_reg && !a_move;
    assign in_accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;

            if (a_step_move)
                b_valid_reg <= 1'b1;
            else if (b_move)
                b_valid_reg <= 1'b0;

            if (b_move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------- input register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_cmd_reg   <= command;
            a_tgt_reg   <= new_target;
            a_pos_reg   <= position;
            a_touch_reg <= touched;
            a_now_reg   <= now_ms;
        end
    end

    // ------------------------------------------------------------ state update
    logic [9:0]         target_reg, target_next;
    logic [16:0]        settle_reg, settle_next;
    logic signed [10:0] last_err_reg;
    logic signed [9:0]  integ_reg, integ_next;
    logic               prev_touch_reg, prev_touch_next;
    logic [32:0]        deadline_reg, deadline_next;
    logic               hold_reg, hold_next;
    logic               rel_reg, rel_next;

    logic [9:0]         clamp_tgt;
    logic signed [10:0] err0, err1;
    logic [10:0]        err0_abs;
    logic [16:0]        settle_limit;
    logic               free_en, follow;
    logic signed [11:0] derr, isum;

    always_comb
    begin
        if (a_tgt_reg > TGT_MAX)
            clamp_tgt = TGT_MAX;
        else if (a_tgt_reg < TGT_MIN)
            clamp_tgt = TGT_MIN;
        else
            clamp_tgt = a_tgt_reg;

        err0         = $signed({1'b0, target_reg}) - $signed({1'b0, a_pos_reg});
        err0_abs     = err0[10] ? 11'(-err0) : 11'(err0);
        settle_limit = {1'b0, lock_cnt_reg} + {1'b0, headroom_reg};

        target_next     = target_reg;
        settle_next     = settle_reg;
        deadline_next   = deadline_reg;
        prev_touch_next = prev_touch_reg;
        hold_next       = hold_reg;
        rel_next        = rel_reg;
        free_en         = 1'b0;
        follow          = 1'b0;

        if (a_cmd_reg == CMD_SET_TARGET)
        begin
            if (clamp_tgt != target_reg)
            begin
                target_next   = clamp_tgt;
                settle_next   = '0;
                deadline_next = '0;
            end
        end
        else
        begin
            // count up while inside the window, down otherwise
            if (err0_abs < {1'b0, window_reg})
            begin
                if (settle_reg < settle_limit)
                    settle_next = settle_reg + 17'd1;
            end
            else if (settle_reg != '0)
            begin
                settle_next = settle_reg - 17'd1;
            end

            // start the release hold timer when touch is let go
            if (prev_touch_reg != a_touch_reg)
            begin
                prev_touch_next = a_touch_reg;
                if (!a_touch_reg)
                    deadline_next = {1'b0, a_now_reg} + {17'd0, delay_reg};
            end

            if (a_touch_reg)
                hold_next = 1'b1;
            else if ({1'b0, a_now_reg} > deadline_next)
                hold_next = 1'b0;

            free_en = hold_mode_reg ? a_touch_reg : hold_next;
            follow  = free_en && !hold_mode_reg;

            if (settle_next > {1'b0, lock_cnt_reg})
                rel_next = 1'b1;
            else if (!free_en)
                rel_next = 1'b0;

            if (free_en)
                rel_next = follow;

            if (follow)
                target_next = a_pos_reg;
        end

        // target equals position when following, so the error drops to zero
        err1 = follow ? '0 : err0;
        derr = 12'(err1) - 12'(last_err_reg);
        isum = 12'(integ_reg) + 12'(err1);
        if (isum <= INTEG_LIMIT && isum >= -INTEG_LIMIT)
            integ_next = isum[9:0];
        else
            integ_next = integ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= TGT_RESET;
            settle_reg     <= '0;
            last_err_reg   <= '0;
            integ_reg      <= '0;
            prev_touch_reg <= 1'b0;
            deadline_reg   <= '0;
            hold_reg       <= 1'b0;
            rel_reg        <= 1'b0;
        end
        else if (a_move)
        begin
            target_reg   <= target_next;
            settle_reg   <= settle_next;
            deadline_reg <= deadline_next;
            if (a_cmd_reg == CMD_STEP)
            begin
                last_err_reg   <= err1;
                integ_reg      <= integ_next;
                prev_touch_reg <= prev_touch_next;
                hold_reg       <= hold_next;
                rel_reg        <= rel_next;
            end
        end
    end

    // -------------------------------------------------------- operand register
    logic signed [10:0] b_err_reg;
    logic signed [11:0] b_derr_reg;
    logic signed [9:0]  b_integ_reg;
    logic               b_rel_reg, b_hold_lim_reg;
    logic [9:0]         b_tgt_reg;

    always_ff @(posedge clk)
    begin
        if (a_step_move)
        begin
            b_err_reg      <= err1;
            b_derr_reg     <= derr;
            b_integ_reg    <= integ_next;
            b_rel_reg      <= rel_next;
            b_hold_lim_reg <= hold_mode_reg && free_en;
            b_tgt_reg      <= target_next;
        end
    end

    // ------------------------------------------------- PID sum, scale, clamp
    logic signed [SUM_W-1:0] p_kp, p_kd, p_ki, pid_sum, sum_adj;
    logic signed [DRV_W-1:0] drv, lim;
    logic signed [8:0]       drive_next;

    always_comb
    begin
        p_kp = SUM_W'($signed({1'b0, kp_reg})) * SUM_W'(b_err_reg);
        p_kd = SUM_W'($signed({1'b0, kd_reg})) * SUM_W'(b_derr_reg);
        p_ki = SUM_W'($signed({1'b0, ki_reg})) * SUM_W'(b_integ_reg);
        pid_sum = p_kp + p_kd + p_ki;

        // divide by 256 rounding toward zero
        sum_adj = pid_sum + (pid_sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
        drv     = DRV_W'(sum_adj >>> 8);

        lim = b_hold_lim_reg ? DRV_W'(HOLD_DRIVE_LIMIT) : DRV_W'(DRIVE_LIMIT);
        if (b_rel_reg)
            drive_next = '0;
        else if (drv > lim)
            drive_next = lim[8:0];
        else if (drv < -lim)
            drive_next = 9'(-lim);
        else
            drive_next = drv[8:0];
    end

    logic signed [8:0] drive_reg;
    logic              released_reg;
    logic [9:0]        tgt_out_reg;

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            drive_reg    <= drive_next;
            released_reg <= b_rel_reg;
            tgt_out_reg  <= b_tgt_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive          = drive_reg;
    assign released       = released_reg;
    assign current_target = tgt_out_reg;

    // -------------------------------------------------------------- checks
    a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (12'(integ_reg) <= INTEG_LIMIT) && (12'(integ_reg) >= -INTEG_LIMIT))
        else $error("integral left its clamp range");

    a_released_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && released |-> drive == 9'sd0)
        else $error("drive nonzero while released");

    a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive <= DRIVE_LIMIT) && (drive >= -DRIVE_LIMIT))
        else $error("drive beyond limit");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_oper_held: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_move |=> b_valid_reg && $stable(b_err_reg))
        else $error("operand register lost a stalled step");

endmodule
